// ===== rtl/vss_pkg.sv =====
`timescale 1ns / 1ps

package vss_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 9;
    localparam int RADIUS_W = 8;
    localparam int SQ_W     = 17;  // square of a 9-bit two's complement value
    localparam int SUM_W    = 18;  // sum of two such squares
    localparam int R2_W     = 16;  // square of the radius
    localparam int ROOT_W   = 8;   // floor square root of a 16-bit value

    // Largest radius that takes effect; larger settings saturate to it.
    localparam int RADIUS_MAX = 255;

    // The integer square root resolves one result bit per step, two steps per stage.
    localparam int ISQRT_STEPS     = R2_W / 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int ISQRT_STAGES    = ISQRT_STEPS / STEPS_PER_STAGE;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One column that hits the sphere, as handed from front to back.
    typedef struct packed {
        logic signed [COORD_W-1:0] i;
        logic signed [COORD_W-1:0] j;
        logic [ROOT_W-1:0]         k;
    } t_qent;

    // Partial remainder and root of the square root recurrence.
    typedef struct packed {
        logic [R2_W-1:0] n;
        logic [R2_W-1:0] root;
    } t_rt;

    // Runs STEPS_PER_STAGE steps of the digit-by-digit square root,
    // starting at step first_step (step 0 handles the top bit pair).
    function automatic t_rt isqrt_steps(input t_rt cur, input int first_step);
        t_rt             res;
        logic [R2_W:0]   trial;
        logic [R2_W-1:0] bitv;
        int              sh;
        res = cur;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            sh    = (R2_W - 2) - 2 * (first_step + s);
            bitv  = R2_W'(1) << sh;
            trial = {1'b0, res.root} + {1'b0, bitv};
            if ({1'b0, res.n} >= trial) begin
                res.n    = R2_W'({1'b0, res.n} - trial);
                res.root = (res.root >> 1) + bitv;
            end else begin
                res.root = res.root >> 1;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/vss_front.sv =====
`timescale 1ns / 1ps

module vss_front
    import vss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [RADIUS_W-1:0]       i_radius,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_col_i,
    input  logic signed [COORD_W-1:0] i_col_j,
    output logic                      o_push,
    output t_qent                     o_push_data,
    input  logic                      i_q_full
);

    typedef struct packed {
        logic                      v;
        logic                      hit;
        logic signed [COORD_W-1:0] i;
        logic signed [COORD_W-1:0] j;
        t_rt                       rt;
    } t_stage;

    // Squaring stage.
    logic                      r_sq_v;
    logic signed [COORD_W-1:0] r_sq_i;
    logic signed [COORD_W-1:0] r_sq_j;
    logic [SQ_W-1:0]           r_sq_ii;
    logic [SQ_W-1:0]           r_sq_jj;
    logic [R2_W-1:0]           r_sq_r2;

    // Stage 0 holds the compare result, stages 1.. run the square root.
    t_stage r_st [0:ISQRT_STAGES];

    logic                      stall;
    logic [RADIUS_W-1:0]       r_eff;
    logic signed [2*COORD_W-1:0] prod_i;
    logic signed [2*COORD_W-1:0] prod_j;
    logic [SUM_W-1:0]          sum;

    // The whole pipeline holds while its finished word cannot enter the queue.
    assign stall   = r_st[ISQRT_STAGES].v && r_st[ISQRT_STAGES].hit && i_q_full;
    assign o_stall = stall;

    assign r_eff  = (int'(i_radius) > RADIUS_MAX) ? RADIUS_W'(RADIUS_MAX) : i_radius;
    assign prod_i = (2*COORD_W)'(i_col_i) * (2*COORD_W)'(i_col_i);
    assign prod_j = (2*COORD_W)'(i_col_j) * (2*COORD_W)'(i_col_j);
    assign sum    = SUM_W'(r_sq_ii) + SUM_W'(r_sq_jj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
            for (int s = 0; s <= ISQRT_STAGES; s++) begin
                r_st[s].v <= 1'b0;
            end
        end else if (!stall) begin
            r_sq_v  <= i_valid;
            r_sq_i  <= i_col_i;
            r_sq_j  <= i_col_j;
            r_sq_ii <= prod_i[SQ_W-1:0];
            r_sq_jj <= prod_j[SQ_W-1:0];
            r_sq_r2 <= R2_W'(r_eff) * R2_W'(r_eff);

            r_st[0].v       <= r_sq_v;
            r_st[0].hit     <= sum <= SUM_W'(r_sq_r2);
            r_st[0].i       <= r_sq_i;
            r_st[0].j       <= r_sq_j;
            r_st[0].rt.n    <= r_sq_r2 - sum[R2_W-1:0];
            r_st[0].rt.root <= '0;

            for (int s = 1; s <= ISQRT_STAGES; s++) begin
                r_st[s].v   <= r_st[s-1].v;
                r_st[s].hit <= r_st[s-1].hit;
                r_st[s].i   <= r_st[s-1].i;
                r_st[s].j   <= r_st[s-1].j;
                r_st[s].rt  <= isqrt_steps(r_st[s-1].rt, (s - 1) * STEPS_PER_STAGE);
            end
        end
    end

    // Columns that miss the sphere fall out here without reaching the queue.
    assign o_push        = r_st[ISQRT_STAGES].v && r_st[ISQRT_STAGES].hit && !i_q_full;
    assign o_push_data.i = r_st[ISQRT_STAGES].i;
    assign o_push_data.j = r_st[ISQRT_STAGES].j;
    assign o_push_data.k = r_st[ISQRT_STAGES].rt.root[ROOT_W-1:0];

endmodule

// ===== rtl/vss_queue.sv =====
`timescale 1ns / 1ps

module vss_queue
    import vss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_push_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nempty,
    output t_qent o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full   = (int'(r_cnt) == QUEUE_DEPTH);
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/vss_back.sv =====
`timescale 1ns / 1ps

module vss_back
    import vss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_nempty,
    input  t_qent                     i_q_data,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_off_x,
    output logic signed [COORD_W-1:0] o_off_y,
    output logic signed [COORD_W-1:0] o_off_z,
    output logic                      o_last_point
);

    // Negative k first, then positive; within each sign the three permutations.
    typedef enum logic [2:0] {
        PH_NEG_Z,
        PH_NEG_X,
        PH_NEG_Y,
        PH_POS_Z,
        PH_POS_X,
        PH_POS_Y
    } t_phase;

    t_phase r_ph;
    t_phase n_ph;
    logic   r_busy;
    t_qent  r_cur;

    logic                      r_ov;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic                      r_last;

    logic                      adv;
    logic                      pop;
    logic signed [COORD_W-1:0] k_pos;
    logic signed [COORD_W-1:0] k_neg;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic                      plast;

    assign k_pos = $signed({1'b0, r_cur.k});
    assign k_neg = -k_pos;

    always_comb begin
        px    = r_cur.i;
        py    = r_cur.j;
        pz    = k_neg;
        plast = 1'b0;
        n_ph  = PH_NEG_Z;
        case (r_ph)
            PH_NEG_Z: begin
                pz   = k_neg;
                n_ph = PH_NEG_X;
            end
            PH_NEG_X: begin
                px   = k_neg;
                pz   = r_cur.i;
                n_ph = PH_NEG_Y;
            end
            PH_NEG_Y: begin
                py   = k_neg;
                pz   = r_cur.j;
                n_ph = PH_POS_Z;
            end
            PH_POS_Z: begin
                pz   = k_pos;
                n_ph = PH_POS_X;
            end
            PH_POS_X: begin
                px   = k_pos;
                pz   = r_cur.i;
                n_ph = PH_POS_Y;
            end
            PH_POS_Y: begin
                py    = k_pos;
                pz    = r_cur.j;
                plast = 1'b1;
                n_ph  = PH_NEG_Z;
            end
            default: begin
                n_ph = PH_NEG_Z;
            end
        endcase
    end

    // A point moves into the output register whenever it is empty or being taken.
    assign adv     = r_busy && (!r_ov || !i_stall);
    assign pop     = i_q_nempty && (!r_busy || (adv && plast));
    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_NEG_Z;
            r_ov   <= 1'b0;
        end else begin
            if (pop) begin
                r_cur  <= i_q_data;
                r_ph   <= PH_NEG_Z;
                r_busy <= 1'b1;
            end else if (adv) begin
                r_ph <= n_ph;
                if (plast) begin
                    r_busy <= 1'b0;
                end
            end

            if (adv) begin
                r_ov   <= 1'b1;
                r_x    <= px;
                r_y    <= py;
                r_z    <= pz;
                r_last <= plast;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_off_x      = r_x;
    assign o_off_y      = r_y;
    assign o_off_z      = r_z;
    assign o_last_point = r_last;

endmodule

// ===== rtl/voxel_sphere_surface_points.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// column    in         i_valid / o_stall    i_col_i, i_col_j
// point     out        o_valid / i_stall    o_off_x, o_off_y, o_off_z, o_last_point
// radius    in         i_radius_we          i_radius_wdata
//
// A column that hits the sphere yields six points, one per cycle while
// i_stall is low, so the point sequencer in the back end limits how fast
// hitting columns are taken; a column that misses yields none. A column
// passes the squaring register, the compare stage, four square root stages,
// the queue, the current-column register and the output register on its way
// to its first point. Reset is synchronous and active low; it empties the
// pipeline, queue and output and sets the radius to eight. A stall on the point
// side fills the queue and then holds the front pipeline, which raises o_stall.

module voxel_sphere_surface_points
    import vss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_radius_we,
    input  logic [RADIUS_W-1:0]       i_radius_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_col_i,
    input  logic signed [COORD_W-1:0] i_col_j,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_off_x,
    output logic signed [COORD_W-1:0] o_off_y,
    output logic signed [COORD_W-1:0] o_off_z,
    output logic                      o_last_point
);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(8);

    logic [RADIUS_W-1:0] r_radius;

    logic  push;
    t_qent push_data;
    logic  q_full;
    logic  q_pop;
    logic  q_nempty;
    t_qent q_data;

    // The user must rewrite the radius only while no column is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    // Front end: squares the coordinates, tests against the radius and
    // finds k with a pipelined integer square root.
    vss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (r_radius),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_col_i     (i_col_i),
        .i_col_j     (i_col_j),
        .o_push      (push),
        .o_push_data (push_data),
        .i_q_full    (q_full)
    );

    // Short queue so that the front keeps working while the back emits points.
    vss_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_nempty    (q_nempty),
        .o_data      (q_data)
    );

    // Back end: walks the six permuted, signed points of each column.
    vss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nempty   (q_nempty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_off_x      (o_off_x),
        .o_off_y      (o_off_y),
        .o_off_z      (o_off_z),
        .o_last_point (o_last_point)
    );

endmodule

// ===== tb/voxel_sphere_point_checker.sv =====
`timescale 1ns / 1ps

module voxel_sphere_point_checker
    import vss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_radius_we,
    input  logic [RADIUS_W-1:0]       i_radius_wdata,
    input  logic                      i_col_valid,
    input  logic                      i_col_stall,
    input  logic signed [COORD_W-1:0] i_col_i,
    input  logic signed [COORD_W-1:0] i_col_j,
    input  logic                      i_pt_valid,
    input  logic                      i_pt_stall,
    input  logic signed [COORD_W-1:0] i_off_x,
    input  logic signed [COORD_W-1:0] i_off_y,
    input  logic signed [COORD_W-1:0] i_off_z,
    input  logic                      i_last_point,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int RADIUS_RESET = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } t_point;

    t_point              surface_points[$];
    logic [RADIUS_W-1:0] radius;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        radius       = RADIUS_W'(RADIUS_RESET);
    end

    // Largest k with k*k <= n, found one bit at a time from the top.
    function automatic int floor_root(input int n);
        int root;
        int trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic push_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input logic                      last);
        t_point p;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        surface_points.push_back(p);
    endtask

    task automatic predict_column(input logic signed [COORD_W-1:0] ci,
                                  input logic signed [COORD_W-1:0] cj);
        int                        eff_r;
        int                        si;
        int                        sj;
        int                        kv;
        logic signed [COORD_W-1:0] sk;
        eff_r = (radius > RADIUS_MAX) ? RADIUS_MAX : int'(radius);
        si    = int'(ci);
        sj    = int'(cj);
        if (si * si + sj * sj > eff_r * eff_r) begin
            return;
        end
        kv = floor_root(eff_r * eff_r - si * si - sj * sj);
        for (int s = 0; s < 2; s++) begin
            sk = COORD_W'((s == 0) ? -kv : kv);
            push_point(ci, cj, sk, 1'b0);
            push_point(sk, cj, ci, 1'b0);
            push_point(ci, sk, cj, s == 1);
        end
    endtask

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            radius = RADIUS_W'(RADIUS_RESET);
            surface_points.delete();
        end else begin
            if (i_pt_valid && !i_pt_stall) begin
                if (surface_points.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected point, expected none, got (%0d,%0d,%0d) last %0d",
                             $time, i_off_x, i_off_y, i_off_z, i_last_point);
                end else begin
                    want = surface_points.pop_front();
                    report_field("off_x", 32'(want.x), 32'(i_off_x));
                    report_field("off_y", 32'(want.y), 32'(i_off_y));
                    report_field("off_z", 32'(want.z), 32'(i_off_z));
                    report_field("last_point", {31'd0, want.last}, {31'd0, i_last_point});
                end
            end
            if (i_col_valid && !i_col_stall) begin
                predict_column(i_col_i, i_col_j);
            end
            if (i_radius_we) begin
                radius = i_radius_wdata;
            end
        end
        o_pending = surface_points.size();
    end

endmodule

// ===== tb/tb_voxel_sphere_surface_points.sv =====
`timescale 1ns / 1ps

module tb_voxel_sphere_surface_points;
    import vss_pkg::*;

    // DRAIN_CYCLES idle cycles after the last point cover a column that missed
    // and may still be inside the pipeline.
    localparam int DRAIN_CYCLES = 16;
    localparam int END_CYCLES   = 24;
    // Far beyond the slowest correct run: every column hitting, every point
    // held by the longest stall the receiver makes, every gap at its longest.
    localparam int TIMEOUT_NS   = 2_000_000;

    // How the point side stalls during one stretch of cycles.
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_LONG} t_rx_mode;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      radius_we;
    logic [RADIUS_W-1:0]       radius_wdata;
    logic                      col_valid;
    logic                      col_stall;
    logic signed [COORD_W-1:0] col_i;
    logic signed [COORD_W-1:0] col_j;
    logic                      pt_valid;
    logic                      pt_stall = 1'b0;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic signed [COORD_W-1:0] off_z;
    logic                      last_point;

    int fail_count;
    int points_pending;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    voxel_sphere_surface_points dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_radius_we    (radius_we),
        .i_radius_wdata (radius_wdata),
        .i_valid        (col_valid),
        .o_stall        (col_stall),
        .i_col_i        (col_i),
        .i_col_j        (col_j),
        .o_valid        (pt_valid),
        .i_stall        (pt_stall),
        .o_off_x        (off_x),
        .o_off_y        (off_y),
        .o_off_z        (off_z),
        .o_last_point   (last_point)
    );

    // The checker watches both channels and the radius port, predicts the six
    // points of every hitting column and compares them in order.
    voxel_sphere_point_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_radius_we    (radius_we),
        .i_radius_wdata (radius_wdata),
        .i_col_valid    (col_valid),
        .i_col_stall    (col_stall),
        .i_col_i        (col_i),
        .i_col_j        (col_j),
        .i_pt_valid     (pt_valid),
        .i_pt_stall     (pt_stall),
        .i_off_x        (off_x),
        .i_off_y        (off_y),
        .i_off_z        (off_z),
        .i_last_point   (last_point),
        .o_fail_count   (fail_count),
        .o_pending      (points_pending)
    );

    // The point side switches at random between stall patterns:
    // wide open, light random stalls, heavy random stalls, and long holds that
    // back the block up until it raises its own stall on the column side.
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;

    always @(negedge clk) begin
        logic stall_next;
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN: begin
                stall_next = 1'b0;
            end
            RX_LIGHT: begin
                stall_next = ($urandom_range(0, 3) == 0);
            end
            RX_HEAVY: begin
                stall_next = ($urandom_range(0, 9) < 6);
            end
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    stall_next = 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    hold_left  = $urandom_range(4, 20);
                    stall_next = 1'b1;
                end else begin
                    stall_next = 1'b0;
                end
            end
        endcase
        pt_stall <= stall_next;
    end

    // Presents one column word at a falling edge and holds it until the block
    // takes it at a rising edge; returns at the following falling edge.
    task automatic send_column(input int ci, input int cj);
        col_valid <= 1'b1;
        col_i     <= ci[COORD_W-1:0];
        col_j     <= cj[COORD_W-1:0];
        @(posedge clk);
        while (col_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // A call with n of zero leaves valid high so back-to-back words keep flowing.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            col_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Holds the column side until every predicted point has come out, then
    // lets the pipeline run empty of any column that missed.
    task automatic drain_points();
        col_valid <= 1'b0;
        while (points_pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // The radius is only changed while the block is idle.
    task automatic write_radius(input int r);
        drain_points();
        radius_we    <= 1'b1;
        radius_wdata <= r[RADIUS_W-1:0];
        @(negedge clk);
        radius_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Random columns in bursts. Most lie inside the square around the sphere,
    // so a large share of them hit; the rest cover the whole 9-bit range,
    // including -256, and miss more often the smaller the radius is.
    task automatic random_columns(input int r, input int count);
        int sent;
        int burst;
        int ci;
        int cj;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++) begin
                if ($urandom_range(0, 4) != 0) begin
                    ci = int'($urandom_range(0, 2 * r)) - r;
                    cj = int'($urandom_range(0, 2 * r)) - r;
                end else begin
                    ci = int'($urandom_range(0, 511)) - 256;
                    cj = int'($urandom_range(0, 511)) - 256;
                end
                send_column(ci, cj);
                sent++;
            end
            // Now and then the sender waits for every point to come back, which
            // also lets the block run completely empty between bursts.
            if ($urandom_range(0, 9) == 0) begin
                drain_points();
            end else if ($urandom_range(0, 2) != 0) begin
                idle_cycles($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        int r;
        rst_n        = 1'b0;
        radius_we    = 1'b0;
        radius_wdata = '0;
        col_valid    = 1'b0;
        col_i        = '0;
        col_j        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        // Directed columns at the radius that reset leaves behind (eight).
        // The center, the rim on each axis where k is zero and the points
        // repeat, near misses, ordinary hits, and the extremes of both fields.
        send_column(0, 0);
        send_column(8, 0);
        send_column(0, -8);
        send_column(-8, 0);
        send_column(9, 0);
        send_column(3, 4);
        send_column(-5, -5);
        send_column(6, 6);
        send_column(-256, 0);
        send_column(0, -256);
        send_column(255, 255);
        send_column(-255, -255);
        send_column(-256, -256);

        // With a radius of zero only the center hits, giving six center points.
        write_radius(0);
        send_column(0, 0);
        send_column(1, 0);
        send_column(0, -1);

        // The largest radius: rim hits on the axes, a diagonal just inside
        // and just outside, and a column just past the rim at (255, 1).
        write_radius(RADIUS_MAX);
        send_column(0, 0);
        send_column(-255, 0);
        send_column(0, 255);
        send_column(180, 180);
        send_column(181, 180);
        send_column(255, 1);
        send_column(-1, -1);

        // Random phases over a spread of radius settings.
        write_radius(255);
        random_columns(255, 60);
        write_radius(1);
        random_columns(1, 40);
        write_radius(0);
        random_columns(0, 16);
        repeat (3) begin
            r = $urandom_range(2, 254);
            write_radius(r);
            random_columns(r, 50);
        end
        write_radius(128);
        random_columns(128, 50);
        write_radius(255);
        random_columns(255, 60);

        // Wait for the last points and watch a while longer for strays.
        drain_points();
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("** voxel_sphere_surface_points: PASSED **");
        end else begin
            $display("** voxel_sphere_surface_points: FAILED **");
        end
        $finish;
    end

    // A hung handshake or a lost point ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("** voxel_sphere_surface_points: FAILED **");
        $finish;
    end

endmodule
